// ===== hdl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Clocked property checks with reset disable, compiled out under ASSERT_OFF.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_PROP(label, clk, rst_n, !(expr), msg)
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hdl/ltc_pkg.sv =====
// ============================================================================
// Lap timer package
// Sizes, register codes, event codes, state type and control structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ltc_pkg;

    localparam int CHANNELS  = 4;
    localparam int CHAN_MAX  = 4;
    localparam int LAP_SLOTS = 16;
    localparam int SLOT_W    = $clog2(LAP_SLOTS);

    localparam int FREQ_W  = 16;
    localparam int RSSI_W  = 16;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;
    localparam int LAPID_W = 16;
    localparam int CH_W    = 2;
    localparam int CFG_W   = 3;

    localparam logic [CNT_W-1:0]   CAL_MAX     = '1;
    localparam logic [LAPID_W-1:0] LAPID_MAX   = '1;
    localparam logic [CNT_W-1:0]   LIMIT_RESET = 8'd3;
    localparam logic [FREQ_W-1:0]  FREQ_RESET [CHAN_MAX] =
        '{16'd5658, 16'd5695, 16'd5732, 16'd5769};

    localparam logic [CFG_W-1:0] CFG_CHAN0_FREQ  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_CHAN1_FREQ  = 3'd1;
    localparam logic [CFG_W-1:0] CFG_CHAN2_FREQ  = 3'd2;
    localparam logic [CFG_W-1:0] CFG_CHAN3_FREQ  = 3'd3;
    localparam logic [CFG_W-1:0] CFG_CHAN0_LIMIT = 3'd4;
    localparam logic [CFG_W-1:0] CFG_CHAN1_LIMIT = 3'd5;
    localparam logic [CFG_W-1:0] CFG_CHAN2_LIMIT = 3'd6;
    localparam logic [CFG_W-1:0] CFG_CHAN3_LIMIT = 3'd7;

    typedef enum logic [2:0] {
        KIND_NO_CHAN     = 3'd0,
        KIND_CALIB_COUNT = 3'd1,
        KIND_CALIB_DONE  = 3'd2,
        KIND_NO_LAP      = 3'd3,
        KIND_LAP         = 3'd4,
        KIND_CALIB_START = 3'd5
    } ltc_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SWEEP,
        ST_FINISH
    } ltc_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic sweep_rd;
        logic emit_lap;
    } ltc_cmd_t;

    typedef struct packed {
        logic lap_hit;
        logic idx_last;
    } ltc_status_t;

endpackage

`default_nettype wire

// ===== hdl/ltc_ctrl.sv =====
// ============================================================================
// Lap timer controller
// Sequences capture, evaluation, ring sweep and lap result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ltc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire ltc_pkg::ltc_status_t st,
    output ltc_pkg::ltc_cmd_t        cmd,
    output logic                     busy
);

    ltc_pkg::ltc_state_t state_reg;
    ltc_pkg::ltc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ltc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ltc_pkg::ST_EVAL;
                end
            end
            ltc_pkg::ST_EVAL:
            begin
                state_next = st.lap_hit ? ltc_pkg::ST_SWEEP : ltc_pkg::ST_IDLE;
            end
            ltc_pkg::ST_SWEEP:
            begin
                if (st.idx_last)
                begin
                    state_next = ltc_pkg::ST_FINISH;
                end
            end
            ltc_pkg::ST_FINISH:
            begin
                state_next = ltc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ltc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ltc_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ltc_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            ltc_pkg::ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
            end
            ltc_pkg::ST_FINISH:
            begin
                cmd.emit_lap = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    `ASSERT_PROP(a_accept_to_eval, clk, rst_n, (start && !busy) |=> (state_reg == ltc_pkg::ST_EVAL), "accepted beat did not enter evaluation")
    `ASSERT_PROP(a_finish_after_sweep, clk, rst_n, (state_reg == ltc_pkg::ST_FINISH) |-> ($past(state_reg) == ltc_pkg::ST_SWEEP), "lap result without a full sweep")

endmodule

`default_nettype wire

// ===== hdl/ltc_datapath.sv =====
// ============================================================================
// Lap timer datapath
// Channel match, calibration counters, lap ring memory and fastest-lap sweep.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ltc_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire ltc_pkg::ltc_cmd_t                  cmd,
    output ltc_pkg::ltc_status_t                    st,
    input  wire logic                               action,
    input  wire logic [ltc_pkg::FREQ_W-1:0]         freq,
    input  wire logic [ltc_pkg::RSSI_W-1:0]         rssi,
    input  wire logic [ltc_pkg::TIME_W-1:0]         time_ms,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ltc_pkg::CFG_W-1:0]          cfg_index,
    input  wire logic [ltc_pkg::FREQ_W-1:0]         cfg_data,
    output logic                                    done,
    output logic [2:0]                              event_kind,
    output logic [ltc_pkg::CH_W-1:0]                channel,
    output logic [ltc_pkg::CNT_W-1:0]               calib_count,
    output logic [ltc_pkg::RSSI_W-1:0]              peak_rssi,
    output logic [ltc_pkg::LAPID_W-1:0]             lap_id,
    output logic [ltc_pkg::TIME_W-1:0]              lap_duration,
    output logic [ltc_pkg::TIME_W-1:0]              fastest_duration,
    output logic [ltc_pkg::TIME_W-1:0]              lap_diff
);

    localparam int SW = ltc_pkg::SLOT_W;
    localparam int TW = ltc_pkg::TIME_W;

    // captured beat
    logic                        act_reg;
    logic [ltc_pkg::FREQ_W-1:0]  freq_reg;
    logic [ltc_pkg::RSSI_W-1:0]  rssi_reg;
    logic [TW-1:0]               time_reg;

    // configuration
    logic [ltc_pkg::FREQ_W-1:0]  chan_freq_reg  [ltc_pkg::CHAN_MAX];
    logic [ltc_pkg::CNT_W-1:0]   chan_limit_reg [ltc_pkg::CHAN_MAX];

    // timing state
    logic                        calib_active_reg [ltc_pkg::CHAN_MAX];
    logic                        calib_active_next [ltc_pkg::CHAN_MAX];
    logic [ltc_pkg::CNT_W-1:0]   calib_passes_reg [ltc_pkg::CHAN_MAX];
    logic [ltc_pkg::CNT_W-1:0]   calib_passes_next [ltc_pkg::CHAN_MAX];
    logic [TW-1:0]               last_time_reg;
    logic [TW-1:0]               last_time_next;
    logic [ltc_pkg::LAPID_W-1:0] lap_counter_reg;
    logic [ltc_pkg::LAPID_W-1:0] lap_counter_next;
    logic [SW-1:0]               slot_reg;
    logic [SW-1:0]               slot_next;
    logic [ltc_pkg::LAP_SLOTS-1:0] ring_valid_reg;
    logic [ltc_pkg::LAP_SLOTS-1:0] ring_valid_next;
    logic [TW-1:0]               ring_mem [ltc_pkg::LAP_SLOTS];

    // sweep
    logic [SW-1:0]               idx_reg;
    logic [SW-1:0]               idx_next;
    logic                        cmp_pending_reg;
    logic                        any_reg;
    logic                        any_next;
    logic [TW-1:0]               fast_reg;
    logic [TW-1:0]               fast_next;
    logic [TW-1:0]               rd_data_reg;
    logic                        rd_valid_reg;
    logic [TW-1:0]               dur_reg;
    logic [ltc_pkg::CH_W-1:0]    lap_chan_reg;

    // evaluation
    logic                        hit;
    logic [ltc_pkg::CH_W-1:0]    hit_ch;
    logic                        cal_act;
    logic [ltc_pkg::CNT_W-1:0]   pass_inc;
    logic                        cal_done;
    logic [TW-1:0]               dur;
    logic                        timed;
    logic                        lap_hit;
    logic                        ring_we;
    logic                        take;
    logic [TW-1:0]               fast_cand;

    // results
    logic                        done_reg;
    logic                        done_next;
    ltc_pkg::ltc_kind_t          kind_reg;
    ltc_pkg::ltc_kind_t          kind_next;
    logic [ltc_pkg::CH_W-1:0]    chan_reg;
    logic [ltc_pkg::CH_W-1:0]    chan_next;
    logic [ltc_pkg::CNT_W-1:0]   count_reg;
    logic [ltc_pkg::CNT_W-1:0]   count_next;
    logic [ltc_pkg::RSSI_W-1:0]  peak_reg;
    logic [ltc_pkg::RSSI_W-1:0]  peak_next;
    logic [ltc_pkg::LAPID_W-1:0] id_reg;
    logic [ltc_pkg::LAPID_W-1:0] id_next;
    logic [TW-1:0]               duration_reg;
    logic [TW-1:0]               duration_next;
    logic [TW-1:0]               fastest_reg;
    logic [TW-1:0]               fastest_next;
    logic [TW-1:0]               diff_reg;
    logic [TW-1:0]               diff_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action;
            freq_reg <= freq;
            rssi_reg <= rssi;
            time_reg <= time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ltc_pkg::CHAN_MAX; i++)
            begin
                chan_freq_reg[i]  <= ltc_pkg::FREQ_RESET[i];
                chan_limit_reg[i] <= ltc_pkg::LIMIT_RESET;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ltc_pkg::CFG_CHAN0_FREQ:  chan_freq_reg[0]  <= cfg_data;
                ltc_pkg::CFG_CHAN1_FREQ:  chan_freq_reg[1]  <= cfg_data;
                ltc_pkg::CFG_CHAN2_FREQ:  chan_freq_reg[2]  <= cfg_data;
                ltc_pkg::CFG_CHAN3_FREQ:  chan_freq_reg[3]  <= cfg_data;
                ltc_pkg::CFG_CHAN0_LIMIT: chan_limit_reg[0] <= cfg_data[ltc_pkg::CNT_W-1:0];
                ltc_pkg::CFG_CHAN1_LIMIT: chan_limit_reg[1] <= cfg_data[ltc_pkg::CNT_W-1:0];
                ltc_pkg::CFG_CHAN2_LIMIT: chan_limit_reg[2] <= cfg_data[ltc_pkg::CNT_W-1:0];
                ltc_pkg::CFG_CHAN3_LIMIT: chan_limit_reg[3] <= cfg_data[ltc_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // lowest matching channel wins
    always_comb
    begin
        hit    = 1'b0;
        hit_ch = '0;
        for (int i = ltc_pkg::CHANNELS - 1; i >= 0; i--)
        begin
            if (chan_freq_reg[i] == freq_reg)
            begin
                hit    = 1'b1;
                hit_ch = ltc_pkg::CH_W'(i);
            end
        end
    end

    assign cal_act  = calib_active_reg[hit_ch];
    assign pass_inc = (calib_passes_reg[hit_ch] == ltc_pkg::CAL_MAX) ?
                      calib_passes_reg[hit_ch] : calib_passes_reg[hit_ch] + 8'd1;
    assign cal_done = pass_inc >= chan_limit_reg[hit_ch];
    assign dur      = time_reg - last_time_reg;
    assign timed    = !act_reg && hit && !cal_act;
    assign lap_hit  = timed && (last_time_reg != '0) && (rssi_reg != '0) && (dur != '0);
    assign ring_we  = cmd.eval && lap_hit;

    assign st.lap_hit  = lap_hit;
    assign st.idx_last = idx_reg == SW'(ltc_pkg::LAP_SLOTS - 1);

    always_comb
    begin
        for (int i = 0; i < ltc_pkg::CHAN_MAX; i++)
        begin
            calib_active_next[i] = calib_active_reg[i];
            calib_passes_next[i] = calib_passes_reg[i];
        end
        last_time_next   = last_time_reg;
        lap_counter_next = lap_counter_reg;
        slot_next        = slot_reg;
        ring_valid_next  = ring_valid_reg;
        if (cmd.eval)
        begin
            if (act_reg)
            begin
                for (int i = 0; i < ltc_pkg::CHANNELS; i++)
                begin
                    calib_active_next[i] = 1'b1;
                    calib_passes_next[i] = '0;
                end
            end
            else if (hit && cal_act)
            begin
                calib_passes_next[hit_ch] = pass_inc;
                if (cal_done)
                begin
                    calib_active_next[hit_ch] = 1'b0;
                end
            end
            else if (timed)
            begin
                last_time_next = time_reg;
                if (lap_hit)
                begin
                    ring_valid_next[slot_reg] = 1'b1;
                    lap_counter_next = lap_counter_reg + 16'd1;
                    // slot tracks the lap counter modulo the ring size
                    if ((lap_counter_reg == ltc_pkg::LAPID_MAX) ||
                        (slot_reg == SW'(ltc_pkg::LAP_SLOTS - 1)))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + SW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ltc_pkg::CHAN_MAX; i++)
            begin
                calib_active_reg[i] <= 1'b0;
                calib_passes_reg[i] <= '0;
            end
            last_time_reg   <= '0;
            lap_counter_reg <= '0;
            slot_reg        <= '0;
            ring_valid_reg  <= '0;
        end
        else
        begin
            for (int i = 0; i < ltc_pkg::CHAN_MAX; i++)
            begin
                calib_active_reg[i] <= calib_active_next[i];
                calib_passes_reg[i] <= calib_passes_next[i];
            end
            last_time_reg   <= last_time_next;
            lap_counter_reg <= lap_counter_next;
            slot_reg        <= slot_next;
            ring_valid_reg  <= ring_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[slot_reg] <= dur;
        end
        rd_data_reg  <= ring_mem[idx_reg];
        rd_valid_reg <= ring_valid_reg[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            dur_reg      <= dur;
            lap_chan_reg <= hit_ch;
        end
    end

    assign take      = cmp_pending_reg && rd_valid_reg &&
                       (!any_reg || (rd_data_reg < fast_reg));
    assign fast_cand = take ? rd_data_reg : fast_reg;

    always_comb
    begin
        idx_next  = idx_reg;
        any_next  = any_reg;
        fast_next = fast_cand;
        if (ring_we)
        begin
            idx_next  = '0;
            any_next  = 1'b0;
            fast_next = '0;
        end
        else
        begin
            if (take)
            begin
                any_next = 1'b1;
            end
            if (cmd.sweep_rd)
            begin
                idx_next = st.idx_last ? '0 : idx_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            any_reg         <= 1'b0;
            cmp_pending_reg <= 1'b0;
        end
        else
        begin
            idx_reg         <= idx_next;
            any_reg         <= any_next;
            cmp_pending_reg <= cmd.sweep_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        fast_reg <= fast_next;
    end

    always_comb
    begin
        done_next     = (cmd.eval && !lap_hit) || cmd.emit_lap;
        kind_next     = ltc_pkg::KIND_NO_LAP;
        chan_next     = '0;
        count_next    = '0;
        peak_next     = '0;
        id_next       = '0;
        duration_next = '0;
        fastest_next  = '0;
        diff_next     = '0;
        if (cmd.emit_lap)
        begin
            kind_next     = ltc_pkg::KIND_LAP;
            chan_next     = lap_chan_reg;
            id_next       = lap_counter_reg;
            duration_next = dur_reg;
            fastest_next  = fast_cand;
            diff_next     = dur_reg - fast_cand;
        end
        else if (act_reg)
        begin
            kind_next = ltc_pkg::KIND_CALIB_START;
        end
        else if (!hit)
        begin
            kind_next = ltc_pkg::KIND_NO_CHAN;
        end
        else if (cal_act)
        begin
            chan_next  = hit_ch;
            count_next = pass_inc;
            if (cal_done)
            begin
                kind_next = ltc_pkg::KIND_CALIB_DONE;
                peak_next = rssi_reg;
            end
            else
            begin
                kind_next = ltc_pkg::KIND_CALIB_COUNT;
            end
        end
        else
        begin
            chan_next = hit_ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            kind_reg     <= kind_next;
            chan_reg     <= chan_next;
            count_reg    <= count_next;
            peak_reg     <= peak_next;
            id_reg       <= id_next;
            duration_reg <= duration_next;
            fastest_reg  <= fastest_next;
            diff_reg     <= diff_next;
        end
    end

    assign done             = done_reg;
    assign event_kind       = kind_reg;
    assign channel          = chan_reg;
    assign calib_count      = count_reg;
    assign peak_rssi        = peak_reg;
    assign lap_id           = id_reg;
    assign lap_duration     = duration_reg;
    assign fastest_duration = fastest_reg;
    assign lap_diff         = diff_reg;

    `ASSERT_NEVER(a_strobe_gap, clk, rst_n, done_reg && $past(done_reg), "two result beats in a row")
    `ASSERT_PROP(a_fastest_bound, clk, rst_n, (done_reg && (kind_reg == ltc_pkg::KIND_LAP)) |-> (fastest_reg <= duration_reg), "fastest lap longer than current lap")
    `ASSERT_PROP(a_slot_marked, clk, rst_n, ring_we |=> ring_valid_reg[$past(slot_reg)], "written ring slot not marked valid")

endmodule

`default_nettype wire

// ===== hdl/lap_timer_with_calibration.sv =====
// ============================================================================
// Lap timer with calibration
// Gate-pass timing, per-channel calibration and fastest-lap tracking.
// ============================================================================
// A beat is taken when start is high and busy is low. Every beat gives one
// result, shown on the result ports for a single cycle while done is high;
// the receiver cannot stall, so it must take the result in that cycle.
// A calibration command, an unmatched pass, a calibration pass or a pass that
// records no lap gives done registered from the evaluation state. A recorded
// lap gives done registered from the finish state after the sweep state: the
// fastest lap is found by sweeping the lap ring memory, one slot per cycle
// through its read port. busy is low again in the cycle that done is high.
// cfg_ready is always high; write configuration only while busy is low.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lap_timer_with_calibration (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic                               action,
    input  wire logic [ltc_pkg::FREQ_W-1:0]         freq,
    input  wire logic [ltc_pkg::RSSI_W-1:0]         rssi,
    input  wire logic [ltc_pkg::TIME_W-1:0]         time_ms,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ltc_pkg::CFG_W-1:0]          cfg_index,
    input  wire logic [ltc_pkg::FREQ_W-1:0]         cfg_data,
    output logic                                    done,
    output logic [2:0]                              event_kind,
    output logic [ltc_pkg::CH_W-1:0]                channel,
    output logic [ltc_pkg::CNT_W-1:0]               calib_count,
    output logic [ltc_pkg::RSSI_W-1:0]              peak_rssi,
    output logic [ltc_pkg::LAPID_W-1:0]             lap_id,
    output logic [ltc_pkg::TIME_W-1:0]              lap_duration,
    output logic [ltc_pkg::TIME_W-1:0]              fastest_duration,
    output logic [ltc_pkg::TIME_W-1:0]              lap_diff
);

    ltc_pkg::ltc_cmd_t    cmd;
    ltc_pkg::ltc_status_t st;

    ltc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    ltc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .action           (action),
        .freq             (freq),
        .rssi             (rssi),
        .time_ms          (time_ms),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .done             (done),
        .event_kind       (event_kind),
        .channel          (channel),
        .calib_count      (calib_count),
        .peak_rssi        (peak_rssi),
        .lap_id           (lap_id),
        .lap_duration     (lap_duration),
        .fastest_duration (fastest_duration),
        .lap_diff         (lap_diff)
    );

endmodule

`default_nettype wire
